// File: hdl/lssfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder package
// Shared types, register indexes, command codes and the bit encoder.
// ----------------------------------------------------------------------------
package lssfe_pkg;

  localparam int unsigned MaxLedsDefault    = 1024;
  localparam int unsigned ResetBytesDefault = 20;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] REG_LED_COUNT  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_BRIGHTNESS = 1'b1;

  localparam logic [10:0] LedCountReset   = 11'd1;
  localparam logic [7:0]  BrightnessReset = 8'd255;

  localparam logic [2:0] SymOne  = 3'b110;
  localparam logic [2:0] SymZero = 3'b100;

  typedef enum logic [1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_START     = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_last;
  } out_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [9:0] idx;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  typedef struct packed {
    logic pop;
    logic init;
  } back_ctl_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  function automatic logic [23:0] encode_byte(input logic [7:0] v);
    logic [23:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[3*i +: 3] = v[i] ? SymOne : SymZero;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hdl/led_strip_spi_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder
// Pixel store with brightness scaling; emits 3-bit-per-bit SPI frame bytes.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_stall_o (set pixel, clear, start, tick).
// A two-entry queue separates the front, which scales colors, from the back,
// which owns the two-port pixel memory and the frame counters.
// Set pixel, start and tick each leave the queue as the back handles them; a
// tick inside a frame produces one byte on out_valid_o/out_stall_i, which is
// registered in the output register. A clear walks the store at one LED per
// cycle, so it holds the back while the queue fills. After reset the same
// sweep runs with in_stall_o high; brightness writes are taken at any time,
// LED count writes only outside a frame.
// When out_stall_i holds the output register, the back stops on the next tick
// and the queue, then in_stall_o, back up behind it.
// ----------------------------------------------------------------------------
module led_strip_spi_frame_encoder #(
  parameter int unsigned MAX_LEDS    = lssfe_pkg::MaxLedsDefault,
  parameter int unsigned RESET_BYTES = lssfe_pkg::ResetBytesDefault
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  lssfe_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output lssfe_pkg::out_t                    out_data_o,
  input  wire                                cfg_we_i,
  input  wire  [lssfe_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [lssfe_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  lssfe_pkg::cfg_wr_t   cfg;
  lssfe_pkg::head_t     head;
  lssfe_pkg::back_ctl_t ctl;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  lssfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .ctl_i      (ctl),
    .head_o     (head)
  );

  lssfe_back #(
    .MAX_LEDS    (MAX_LEDS),
    .RESET_BYTES (RESET_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .ctl_o       (ctl),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: hdl/lssfe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder front end
// Accepts requests, scales colors by brightness and queues them for the back.
// ----------------------------------------------------------------------------
module lssfe_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  lssfe_pkg::in_t        in_data_i,
  input  lssfe_pkg::cfg_wr_t    cfg_i,
  input  lssfe_pkg::back_ctl_t  ctl_i,
  output lssfe_pkg::head_t      head_o
);

  lssfe_pkg::req_t fifo_q [2];
  logic            wp_q, wp_d;
  logic            rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [7:0]      bright_q, bright_d;
  logic            push;
  lssfe_pkg::req_t req;

  function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] br);
    logic [16:0] p;
    p = {9'd0, v} * {8'd0, ({1'b0, br} + 9'd1)};
    return p[15:8];
  endfunction

  assign in_stall_o = (cnt_q == 2'd2) || ctl_i.init;
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    req.cmd = lssfe_pkg::cmd_e'(in_data_i.command);
    req.idx = in_data_i.pixel_index;
    req.g   = scale(in_data_i.green, bright_q);
    req.r   = scale(in_data_i.red, bright_q);
    req.b   = scale(in_data_i.blue, bright_q);
  end

  always_comb begin
    wp_d     = push ? ~wp_q : wp_q;
    rp_d     = ctl_i.pop ? ~rp_q : rp_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, ctl_i.pop};
    bright_d = bright_q;
    if (cfg_i.we && cfg_i.idx == lssfe_pkg::REG_BRIGHTNESS) begin
      bright_d = cfg_i.data[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= 1'b0;
      rp_q     <= 1'b0;
      cnt_q    <= 2'd0;
      bright_q <= lssfe_pkg::BrightnessReset;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      cnt_q    <= cnt_d;
      bright_q <= bright_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= req;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.req   = fifo_q[rp_q];

endmodule
`default_nettype wire

// File: hdl/lssfe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder back end
// Holds the pixel store, runs clear sweeps and emits frame bytes.
// ----------------------------------------------------------------------------
module lssfe_back #(
  parameter int unsigned MAX_LEDS    = lssfe_pkg::MaxLedsDefault,
  parameter int unsigned RESET_BYTES = lssfe_pkg::ResetBytesDefault
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lssfe_pkg::head_t      head_i,
  output lssfe_pkg::back_ctl_t  ctl_o,
  input  lssfe_pkg::cfg_wr_t    cfg_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output lssfe_pkg::out_t       out_data_o
);

  localparam int unsigned AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CW  = $clog2(MAX_LEDS + 1);
  localparam int unsigned RBW = (RESET_BYTES > 1) ? $clog2(RESET_BYTES) : 1;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PAYLOAD = 2'd1;
  localparam logic [1:0] ST_TAIL    = 2'd2;
  localparam logic [1:0] ST_CLEAR   = 2'd3;

  logic [23:0]     mem [MAX_LEDS];
  logic [23:0]     rd_q;
  logic            we;
  logic [AW-1:0]   wa;
  logic [23:0]     wd;

  logic [1:0]      state_q, state_d;
  logic            init_q, init_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   led_q, led_d;
  logic [1:0]      col_q, col_d;
  logic [1:0]      sym_q, sym_d;
  logic [RBW-1:0]  tail_q, tail_d;
  logic [CW-1:0]   leds_q, leds_d;
  logic            ov_q, ov_d;
  lssfe_pkg::out_t od_q, od_d;

  logic            can_out;
  logic            pop;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;
  logic [7:0]      color;
  logic [23:0]     enc;
  lssfe_pkg::req_t h;

  assign h       = head_i.req;
  assign can_out = !ov_q || !out_stall_i;
  assign pop     = head_i.valid && (state_q != ST_CLEAR) &&
                   (h.cmd != lssfe_pkg::CMD_TICK || can_out);

  always_comb begin
    case (col_q)
      2'd0:    color = rd_q[23:16];
      2'd1:    color = rd_q[15:8];
      default: color = rd_q[7:0];
    endcase
    enc = lssfe_pkg::encode_byte(color);
  end

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    clr_d     = clr_q;
    led_d     = led_q;
    col_d     = col_q;
    sym_d     = sym_q;
    tail_d    = tail_q;
    leds_d    = leds_q;
    we        = 1'b0;
    wa        = AW'(h.idx);
    wd        = {h.g, h.r, h.b};
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (h.cmd)
            lssfe_pkg::CMD_SET_PIXEL: begin
              we = (32'(h.idx) < 32'(leds_q));
            end
            lssfe_pkg::CMD_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            lssfe_pkg::CMD_START: begin
              state_d = ST_PAYLOAD;
              led_d   = '0;
              col_d   = 2'd0;
              sym_d   = 2'd0;
            end
            default: ;
          endcase
        end
      end
      ST_PAYLOAD: begin
        if (pop && h.cmd == lssfe_pkg::CMD_TICK) begin
          emit = 1'b1;
          case (sym_q)
            2'd0:    emit_byte = enc[23:16];
            2'd1:    emit_byte = enc[15:8];
            default: emit_byte = enc[7:0];
          endcase
          if (sym_q == 2'd2) begin
            sym_d = 2'd0;
            if (col_q == 2'd2) begin
              col_d = 2'd0;
              if (32'(led_q) + 32'd1 == 32'(leds_q)) begin
                state_d = ST_TAIL;
                tail_d  = '0;
              end else begin
                led_d = led_q + AW'(1);
              end
            end else begin
              col_d = col_q + 2'd1;
            end
          end else begin
            sym_d = sym_q + 2'd1;
          end
        end
      end
      ST_TAIL: begin
        if (pop && h.cmd == lssfe_pkg::CMD_TICK) begin
          emit = 1'b1;
          if (32'(tail_q) == RESET_BYTES - 1) begin
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            tail_d = tail_q + RBW'(1);
          end
        end
      end
      default: begin
        we = 1'b1;
        wa = clr_q;
        wd = '0;
        if (32'(clr_q) == MAX_LEDS - 1) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
    endcase

    if (cfg_i.we && cfg_i.idx == lssfe_pkg::REG_LED_COUNT &&
        state_q != ST_PAYLOAD && state_q != ST_TAIL) begin
      if (cfg_i.data == '0) begin
        leds_d = CW'(1);
      end else if (32'(cfg_i.data) > MAX_LEDS) begin
        leds_d = CW'(MAX_LEDS);
      end else begin
        leds_d = CW'(cfg_i.data);
      end
    end

    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    if (emit) begin
      ov_d            = 1'b1;
      od_d.spi_byte   = emit_byte;
      od_d.frame_last = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      init_q  <= 1'b1;
      clr_q   <= '0;
      led_q   <= '0;
      col_q   <= 2'd0;
      sym_q   <= 2'd0;
      tail_q  <= '0;
      leds_q  <= CW'(lssfe_pkg::LedCountReset);
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      clr_q   <= clr_d;
      led_q   <= led_d;
      col_q   <= col_d;
      sym_q   <= sym_d;
      tail_q  <= tail_d;
      leds_q  <= leds_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[led_d];
  end

  assign ctl_o.pop   = pop;
  assign ctl_o.init  = init_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip SPI frame encoder testbench
// Drives pixel, clear, start and tick requests with random gaps and output
// stalls. A scoreboard keeps its own pixel store and frame counters and
// predicts every SPI byte. Phases run over several strip lengths and
// brightness levels, a zero count and a longer strip included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StoreDepth   = 3 * lssfe_pkg::MaxLedsDefault;
  localparam int unsigned SettleCycles = 2 * lssfe_pkg::MaxLedsDefault + 64;
  localparam int unsigned RandomItems  = 600;
  localparam int unsigned CycleLimit   = 6000000;

  class strip_frame_checker;
    logic [7:0]      grb_store [StoreDepth];
    bit              in_frame;
    int unsigned     next_pos;
    logic [23:0]     sym_word;
    logic [10:0]     led_count_reg;
    logic [7:0]      bright_reg;
    lssfe_pkg::out_t pending_bytes [$];
    int unsigned     mismatches;
    int unsigned     bytes_checked;
    int unsigned     frames_done;
    int unsigned     requests_seen;
    int unsigned     effective_requests;

    function new();
      foreach (grb_store[k]) grb_store[k] = '0;
      in_frame      = 1'b0;
      next_pos      = 0;
      sym_word      = '0;
      led_count_reg = lssfe_pkg::LedCountReset;
      bright_reg    = lssfe_pkg::BrightnessReset;
    endfunction

    function int unsigned leds_used();
      int unsigned n;
      n = led_count_reg;
      if (n == 0) n = 1;
      if (n > lssfe_pkg::MaxLedsDefault) n = lssfe_pkg::MaxLedsDefault;
      return n;
    endfunction

    function logic [7:0] scale(logic [7:0] v);
      int unsigned p;
      p = v * (bright_reg + 1);
      return 8'(p >> 8);
    endfunction

    function void apply_reg(logic [lssfe_pkg::CfgIdxW-1:0] idx,
                            logic [lssfe_pkg::CfgDataW-1:0] d);
      if (idx == lssfe_pkg::REG_LED_COUNT) begin
        if (!in_frame) led_count_reg = d;
      end else if (idx == lssfe_pkg::REG_BRIGHTNESS) begin
        bright_reg = d[7:0];
      end
    endfunction

    function void take_request(lssfe_pkg::in_t q);
      lssfe_pkg::out_t e;
      int unsigned     payload;
      int unsigned     sub;
      bit              used;
      used = 1'b0;
      requests_seen++;
      case (lssfe_pkg::cmd_e'(q.command))
        lssfe_pkg::CMD_SET_PIXEL: begin
          if (!in_frame && q.pixel_index < leds_used()) begin
            grb_store[3 * q.pixel_index]     = scale(q.green);
            grb_store[3 * q.pixel_index + 1] = scale(q.red);
            grb_store[3 * q.pixel_index + 2] = scale(q.blue);
            used = 1'b1;
          end
        end
        lssfe_pkg::CMD_CLEAR: begin
          if (!in_frame) begin
            foreach (grb_store[k]) grb_store[k] = '0;
            used = 1'b1;
          end
        end
        lssfe_pkg::CMD_START: begin
          if (!in_frame) begin
            in_frame = 1'b1;
            next_pos = 0;
            used     = 1'b1;
          end
        end
        lssfe_pkg::CMD_TICK: begin
          if (in_frame) begin
            payload    = leds_used() * 9;
            e.spi_byte = '0;
            if (next_pos < payload) begin
              sub = next_pos % 3;
              if (sub == 0) begin
                sym_word = '0;
                for (int k = 7; k >= 0; k--)
                  sym_word = {sym_word[20:0],
                              grb_store[next_pos / 3][k] ? lssfe_pkg::SymOne
                                                         : lssfe_pkg::SymZero};
              end
              e.spi_byte = sym_word[23 - 8 * sub -: 8];
            end
            next_pos++;
            e.frame_last = (next_pos >= payload + lssfe_pkg::ResetBytesDefault);
            if (e.frame_last) begin
              in_frame = 1'b0;
              next_pos = 0;
              frames_done++;
            end
            pending_bytes.push_back(e);
            used = 1'b1;
          end
        end
        default: ;
      endcase
      if (used) effective_requests++;
    endfunction

    function void check_byte(lssfe_pkg::out_t got);
      lssfe_pkg::out_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte %0d: none expected, got spi_byte %02h frame_last %0b",
                   bytes_checked, got.spi_byte, got.frame_last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.spi_byte !== want.spi_byte || got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte %0d: expected spi_byte %02h frame_last %0b, got %02h %0b",
                   bytes_checked, want.spi_byte, want.frame_last,
                   got.spi_byte, got.frame_last);
      end
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  lssfe_pkg::in_t                 in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  lssfe_pkg::out_t                out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [lssfe_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [lssfe_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  strip_frame_checker chk;
  bit                 calm = 1'b0;
  int unsigned        stall_left = 0;
  int unsigned        cycles = 0;
  int unsigned        settings_used = 0;

  led_strip_spi_frame_encoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned idle_gap();
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic lssfe_pkg::in_t mk(lssfe_pkg::cmd_e c, logic [9:0] idx,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
    lssfe_pkg::in_t q;
    q.command     = c;
    q.pixel_index = idx;
    q.red         = r;
    q.green       = g;
    q.blue        = b;
    return q;
  endfunction

  function automatic lssfe_pkg::in_t noisy(lssfe_pkg::cmd_e c, logic [9:0] idx);
    return mk(c, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("run exceeded %0d cycles, %0d bytes still expected", CycleLimit,
               chk.pending_bytes.size());
      $display("** led_strip_spi_frame_encoder: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) chk.check_byte(out_data_o);
      if (in_valid_i && !in_stall_o) chk.take_request(in_data_i);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_gap();
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input lssfe_pkg::in_t q);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [lssfe_pkg::CfgIdxW-1:0] idx,
                           input logic [lssfe_pkg::CfgDataW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    chk.apply_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain expected bytes, then let queued clears finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (chk.pending_bytes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic close_frame(input int unsigned noise_pct);
    while (chk.in_frame) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_request(noisy(lssfe_pkg::cmd_e'($urandom_range(0, 2)), 10'($urandom)));
      else
        send_request(noisy(lssfe_pkg::CMD_TICK, 10'($urandom)));
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned goal;
    int unsigned pick;
    goal = chk.effective_requests + quota;
    while (chk.effective_requests < goal) begin
      pick = $urandom_range(0, 99);
      if (chk.in_frame) begin
        if (pick < 88)      send_request(noisy(lssfe_pkg::CMD_TICK, 10'($urandom)));
        else if (pick < 93) send_request(noisy(lssfe_pkg::CMD_SET_PIXEL, 10'($urandom)));
        else if (pick < 97) send_request(noisy(lssfe_pkg::CMD_START, 10'($urandom)));
        else                send_request(noisy(lssfe_pkg::CMD_CLEAR, 10'($urandom)));
      end else begin
        if (pick < 50)
          send_request(noisy(lssfe_pkg::CMD_SET_PIXEL,
                             10'($urandom_range(0, chk.leds_used() - 1))));
        else if (pick < 58) send_request(noisy(lssfe_pkg::CMD_SET_PIXEL, 10'($urandom)));
        else if (pick < 76) send_request(noisy(lssfe_pkg::CMD_START, 10'($urandom)));
        else if (pick < 88) send_request(noisy(lssfe_pkg::CMD_TICK, 10'($urandom)));
        else if (pick < 90) send_request(noisy(lssfe_pkg::CMD_CLEAR, 10'($urandom)));
        else
          send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'(chk.leds_used() - 1),
                          $urandom_range(0, 1) ? 8'hFF : 8'h00,
                          $urandom_range(0, 1) ? 8'hFF : 8'h00,
                          $urandom_range(0, 1) ? 8'hFF : 8'h00));
      end
    end
    close_frame(5);
  endtask

  task automatic long_strip_phase(input logic [lssfe_pkg::CfgDataW-1:0] count_code);
    settings_used++;
    cfg_write(lssfe_pkg::REG_LED_COUNT, count_code);
    cfg_write(lssfe_pkg::REG_BRIGHTNESS, 11'($urandom_range(0, 255)));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'(chk.leds_used() - 1),
                    8'hFF, 8'hFF, 8'hFF));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'h000, 8'h00, 8'hFF, 8'h00));
    repeat (20)
      send_request(noisy(lssfe_pkg::CMD_SET_PIXEL,
                         10'($urandom_range(0, chk.leds_used() - 1))));
    send_request(noisy(lssfe_pkg::CMD_START, 10'($urandom)));
    close_frame(2);
    settle();
  endtask

  initial begin
    int unsigned done;
    int unsigned mark;
    int unsigned sel;
    int unsigned count;
    int unsigned bright;
    chk = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one LED, full brightness
    send_request(mk(lssfe_pkg::CMD_TICK, 10'h2A5, 8'h5A, 8'hC3, 8'h0F));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd0, 8'hFF, 8'h00, 8'hA5));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd1, 8'h12, 8'h34, 8'h56));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'h3FF, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk(lssfe_pkg::CMD_START, 10'h155, 8'h00, 8'h00, 8'h00));
    send_request(mk(lssfe_pkg::CMD_START, 10'h0AA, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd0, 8'h00, 8'h00, 8'h00));
    send_request(mk(lssfe_pkg::CMD_CLEAR, 10'h3FF, 8'hFF, 8'hFF, 8'hFF));
    repeat (3) send_request(noisy(lssfe_pkg::CMD_TICK, 10'h155));
    settle();
    settings_used++;
    cfg_write(lssfe_pkg::REG_LED_COUNT, 11'd3);
    cfg_write(lssfe_pkg::REG_BRIGHTNESS, 11'd0);
    close_frame(0);
    settle();
    cfg_write(lssfe_pkg::REG_LED_COUNT, 11'd2);
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd0, 8'hFF, 8'hFF, 8'hFF));
    settle();
    settings_used++;
    cfg_write(lssfe_pkg::REG_BRIGHTNESS, 11'd127);
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd1, 8'h80, 8'hFF, 8'h01));
    send_request(mk(lssfe_pkg::CMD_SET_PIXEL, 10'd2, 8'hFF, 8'hFF, 8'hFF));
    send_request(mk(lssfe_pkg::CMD_START, 10'd0, 8'h00, 8'h00, 8'h00));
    close_frame(0);
    send_request(mk(lssfe_pkg::CMD_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00));
    send_request(mk(lssfe_pkg::CMD_START, 10'd0, 8'h00, 8'h00, 8'h00));
    close_frame(0);
    settle();

    long_strip_phase(11'd32);

    done = 0;
    while (done < RandomItems) begin
      calm  = ($urandom_range(0, 3) == 0);
      sel   = $urandom_range(0, 9);
      count = (sel == 0) ? 0 : (sel < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      sel   = $urandom_range(0, 9);
      bright = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      settings_used++;
      cfg_write(lssfe_pkg::REG_LED_COUNT, 11'(count));
      cfg_write(lssfe_pkg::REG_BRIGHTNESS, 11'(bright));
      mark = chk.requests_seen;
      random_phase($urandom_range(80, 160));
      done += chk.requests_seen - mark;
      settle();
    end

    $display("Sent %0d requests (%0d took effect) under %0d register settings.",
             chk.requests_seen, chk.effective_requests, settings_used);
    $display("Checked %0d SPI bytes in %0d frames, %0d mismatches, %0d bytes missing.",
             chk.bytes_checked, chk.frames_done, chk.mismatches, chk.pending_bytes.size());
    if (chk.mismatches == 0 && chk.pending_bytes.size() == 0)
      $display("** led_strip_spi_frame_encoder: PASSED **");
    else
      $display("** led_strip_spi_frame_encoder: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/lssfe_pkg.sv
hdl/lssfe_front.sv
hdl/lssfe_back.sv
hdl/led_strip_spi_frame_encoder.sv
sim/tb_top.sv
